// ----- sv/rpc_pkg.sv -----
// rpc_pkg: shared types, codes and constants of the reel position controller
// no dependencies; used by the interfaces and every module of the block

package rpc_pkg;

    typedef logic signed [15:0] depth_t;
    typedef logic [15:0]        tick_t;

    // event kinds as they arrive on the request channel
    localparam logic [2:0] KIND_POLL  = 3'd0;
    localparam logic [2:0] KIND_CLICK = 3'd1;
    localparam logic [2:0] KIND_LIMIT = 3'd2;
    localparam logic [2:0] KIND_PWM   = 3'd3;
    localparam logic [2:0] KIND_START = 3'd4;

    // poll status codes
    localparam logic [2:0] STAT_IDLE    = 3'd0;
    localparam logic [2:0] STAT_DOWN    = 3'd1;
    localparam logic [2:0] STAT_UP      = 3'd2;
    localparam logic [2:0] STAT_TIMEOUT = 3'd3;
    localparam logic [2:0] STAT_LIMIT   = 3'd4;

    // motor drive and direction codes share one encoding
    localparam logic [1:0] MOVE_STOP = 2'd0;
    localparam logic [1:0] MOVE_DOWN = 2'd1;
    localparam logic [1:0] MOVE_UP   = 2'd2;

    // event codes
    localparam logic [1:0] EVT_NONE   = 2'd0;
    localparam logic [1:0] EVT_HOME   = 2'd1;
    localparam logic [1:0] EVT_LIMERR = 2'd2;
    localparam logic [1:0] EVT_OOB    = 2'd3;

    // configuration register indexes
    localparam int unsigned     CFG_INDEX_W = 3;
    localparam logic [2:0] REG_TIMEOUT_INNER = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_OUTER = 3'd1;
    localparam logic [2:0] REG_MAX_DEPTH     = 3'd2;
    localparam logic [2:0] REG_MIN_DEPTH     = 3'd3;
    localparam logic [2:0] REG_LIMIT_WINDOW  = 3'd4;
    localparam logic [2:0] REG_PWM_NEUTRAL   = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_TIMEOUT_INNER = 16'd1000;
    localparam logic [15:0] RST_TIMEOUT_OUTER = 16'd100;
    localparam logic [14:0] RST_MAX_DEPTH     = 15'd10000;
    localparam depth_t      RST_MIN_DEPTH     = 16'sd0;
    localparam logic [14:0] RST_LIMIT_WINDOW  = 15'd50;
    localparam logic [15:0] RST_PWM_NEUTRAL   = 16'd3000;

    // depth that a pwm-forced pull-up heads for
    localparam depth_t PULLUP_TARGET = -16'sd10;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_POLL,
        OP_CLICK,
        OP_LIMIT,
        OP_PWM,
        OP_START
    } op_t;

    typedef struct packed {
        op_t    op;
        depth_t target;
        logic   released;
        logic   rising;
        tick_t  timer;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [15:0] timeout_inner;
        logic [15:0] timeout_outer;
        logic [14:0] max_depth;
        depth_t      min_depth;
        logic [14:0] limit_window;
        logic [15:0] pwm_neutral;
    } cfg_t;

    typedef struct packed {
        logic [2:0] poll_status;
        logic [1:0] motor_drive;
        depth_t     depth;
        logic [1:0] direction;
        logic       stop_flag;
        logic [1:0] event_code;
        logic       pullup_active;
        depth_t     held_target;
        tick_t      pulse_width;
    } result_t;

endpackage

// ----- sv/rpc_if.sv -----
// rpc_if: valid/ready channel interfaces for events, results and config writes
// depends on rpc_pkg

interface rpc_evt_if;
    import rpc_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    depth_t     target_depth;
    logic       limit_level;
    logic       pwm_level;
    tick_t      timer_value;

    modport source (output valid, kind, target_depth, limit_level, pwm_level, timer_value,
                    input ready);
    modport sink   (input valid, kind, target_depth, limit_level, pwm_level, timer_value,
                    output ready);
endinterface

interface rpc_res_if;
    import rpc_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] poll_status;
    logic [1:0] motor_drive;
    depth_t     depth;
    logic [1:0] direction;
    logic       stop_flag;
    logic [1:0] event_code;
    logic       pullup_active;
    depth_t     held_target;
    tick_t      pulse_width;

    modport source (output valid, poll_status, motor_drive, depth, direction, stop_flag,
                    event_code, pullup_active, held_target, pulse_width,
                    input ready);
    modport sink   (input valid, poll_status, motor_drive, depth, direction, stop_flag,
                    event_code, pullup_active, held_target, pulse_width,
                    output ready);
endinterface

interface rpc_cfg_if;
    import rpc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rpc_front.sv -----
// rpc_front: accepts event requests and decodes them into queue commands
// depends on rpc_pkg and rpc_if

module rpc_front (
    rpc_evt_if.sink           evt,
    input  rpc_pkg::q_status_t q_status,
    output logic              push,
    output rpc_pkg::cmd_t     cmd
);
    import rpc_pkg::*;

    assign evt.ready = !q_status.full;
    assign push      = evt.valid && !q_status.full;

    always_comb
    begin
        cmd.target   = evt.target_depth;
        cmd.released = evt.limit_level;
        cmd.rising   = evt.pwm_level;
        cmd.timer    = evt.timer_value;
        case (evt.kind)
            KIND_POLL:  cmd.op = OP_POLL;
            KIND_CLICK: cmd.op = OP_CLICK;
            KIND_LIMIT: cmd.op = OP_LIMIT;
            KIND_PWM:   cmd.op = OP_PWM;
            KIND_START: cmd.op = OP_START;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- sv/rpc_queue.sv -----
// rpc_queue: two-entry command queue between front and back
// depends on rpc_pkg

module rpc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rpc_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output rpc_pkg::cmd_t      head_cmd,
    output rpc_pkg::q_status_t status
);
    import rpc_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/rpc_exec.sv -----
// rpc_exec: back end; unless a held result stalls it, applies one command
// per cycle to the state, result in an output register; uses rpc_pkg, rpc_if

module rpc_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  rpc_pkg::cfg_t      cfg,
    input  rpc_pkg::cmd_t      cmd,
    input  rpc_pkg::q_status_t q_status,
    output logic               pop,
    rpc_res_if.source          res
);
    import rpc_pkg::*;

    depth_t     depth_reg, depth_next;
    logic [1:0] dir_reg, dir_next;
    logic       running_reg, running_next;
    logic       stop_reg, stop_next;
    logic       pullup_reg, pullup_next;
    logic [1:0] event_reg, event_next;
    depth_t     hold_reg, hold_next;
    tick_t      rise_reg, rise_next;
    tick_t      width_reg, width_next;
    tick_t      tlow_reg, tlow_next;
    tick_t      thigh_reg, thigh_next;
    logic [1:0] motor_reg, motor_next;
    logic [2:0] status_next;
    logic       out_valid_reg;
    result_t    out_reg;

    assign pop = !q_status.empty && (!out_valid_reg || res.ready);

    always_comb
    begin
        tick_t tl_inc;
        depth_t d;
        depth_next   = depth_reg;
        dir_next     = dir_reg;
        running_next = running_reg;
        stop_next    = stop_reg;
        pullup_next  = pullup_reg;
        event_next   = event_reg;
        hold_next    = hold_reg;
        rise_next    = rise_reg;
        width_next   = width_reg;
        tlow_next    = tlow_reg;
        thigh_next   = thigh_reg;
        motor_next   = motor_reg;
        status_next  = STAT_IDLE;
        tl_inc       = tlow_reg + 16'd1;
        d            = depth_reg;

        case (cmd.op)
            OP_POLL:
            begin
                tlow_next = tl_inc;
                if (tl_inc > cfg.timeout_inner)
                begin
                    tlow_next  = 16'd0;
                    thigh_next = thigh_reg + 16'd1;
                end
                if (thigh_next > cfg.timeout_outer)
                begin
                    stop_next   = 1'b1;
                    status_next = STAT_TIMEOUT;
                end
                else if ((depth_reg != cmd.target) && cmd.released)
                begin
                    if (depth_reg > cmd.target)
                    begin
                        dir_next    = MOVE_DOWN;
                        motor_next  = MOVE_DOWN;
                        status_next = STAT_DOWN;
                    end
                    else
                    begin
                        dir_next    = MOVE_UP;
                        motor_next  = MOVE_UP;
                        status_next = STAT_UP;
                    end
                end
                else
                begin
                    dir_next     = MOVE_STOP;
                    running_next = 1'b0;
                    motor_next   = MOVE_STOP;
                    stop_next    = 1'b1;
                    if (!cmd.released)
                    begin
                        event_next  = EVT_LIMERR;
                        status_next = STAT_LIMIT;
                    end
                end
            end
            OP_CLICK:
            begin
                if (running_reg && dir_reg == MOVE_UP)
                begin
                    d = depth_reg + 16'sd1;
                end
                else if (running_reg && dir_reg == MOVE_DOWN)
                begin
                    d = depth_reg - 16'sd1;
                end
                if ($signed({d[15], d}) > $signed({2'b00, cfg.max_depth}))
                begin
                    stop_next    = 1'b1;
                    running_next = 1'b0;
                    event_next   = EVT_OOB;
                end
                depth_next = (d < cfg.min_depth) ? 16'sd0 : d;
                tlow_next  = 16'd0;
                thigh_next = 16'd0;
            end
            OP_LIMIT:
            begin
                running_next = 1'b0;
                stop_next    = 1'b1;
                if (dir_reg == MOVE_UP && running_reg &&
                    $signed({depth_reg[15], depth_reg}) < $signed({2'b00, cfg.limit_window}))
                begin
                    // homed while reeling up
                    depth_next = 16'sd0;
                    dir_next   = MOVE_STOP;
                    event_next = pullup_reg ? EVT_NONE : EVT_HOME;
                end
                else
                begin
                    event_next = EVT_LIMERR;
                end
            end
            OP_PWM:
            begin
                if (cmd.rising)
                begin
                    rise_next = cmd.timer;
                end
                else
                begin
                    width_next = cmd.timer - rise_reg;
                end
                if (width_next < cfg.pwm_neutral)
                begin
                    hold_next    = PULLUP_TARGET;
                    running_next = 1'b1;
                    dir_next     = MOVE_DOWN;
                    stop_next    = 1'b0;
                    pullup_next  = 1'b1;
                    tlow_next    = 16'd0;
                    thigh_next   = 16'd0;
                end
                else if (pullup_reg)
                begin
                    running_next = 1'b0;
                    event_next   = EVT_NONE;
                    hold_next    = depth_reg;
                    stop_next    = 1'b1;
                    pullup_next  = 1'b0;
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
                stop_next    = 1'b0;
                tlow_next    = 16'd0;
                thigh_next   = 16'd0;
                event_next   = EVT_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= 16'sd0;
            dir_reg       <= MOVE_STOP;
            running_reg   <= 1'b0;
            stop_reg      <= 1'b1;
            pullup_reg    <= 1'b0;
            event_reg     <= EVT_NONE;
            hold_reg      <= 16'sd0;
            rise_reg      <= 16'd0;
            width_reg     <= 16'd0;
            tlow_reg      <= 16'd0;
            thigh_reg     <= 16'd0;
            motor_reg     <= MOVE_STOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                depth_reg   <= depth_next;
                dir_reg     <= dir_next;
                running_reg <= running_next;
                stop_reg    <= stop_next;
                pullup_reg  <= pullup_next;
                event_reg   <= event_next;
                hold_reg    <= hold_next;
                rise_reg    <= rise_next;
                width_reg   <= width_next;
                tlow_reg    <= tlow_next;
                thigh_reg   <= thigh_next;
                motor_reg   <= motor_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.poll_status   <= status_next;
            out_reg.motor_drive   <= motor_next;
            out_reg.depth         <= depth_next;
            out_reg.direction     <= dir_next;
            out_reg.stop_flag     <= stop_next;
            out_reg.event_code    <= event_next;
            out_reg.pullup_active <= pullup_next;
            out_reg.held_target   <= hold_next;
            out_reg.pulse_width   <= width_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.poll_status   = out_reg.poll_status;
    assign res.motor_drive   = out_reg.motor_drive;
    assign res.depth         = out_reg.depth;
    assign res.direction     = out_reg.direction;
    assign res.stop_flag     = out_reg.stop_flag;
    assign res.event_code    = out_reg.event_code;
    assign res.pullup_active = out_reg.pullup_active;
    assign res.held_target   = out_reg.held_target;
    assign res.pulse_width   = out_reg.pulse_width;

endmodule

// ----- sv/reel_position_controller.sv -----
// reel_position_controller: top level; config registers, front decode,
// command queue and back-end executor; depends on rpc_pkg, rpc_if and submodules
// path: a request is written into the queue, then into rpc_exec's result register
// throughput: one request per cycle unless held results stall the back end
// stalls: a held result stops the back end, the queue fills and then drops evt.ready
// reset: state to its idle values with the stop flag set, config to defaults

module reel_position_controller (
    input  logic      clk,
    input  logic      rst_n,
    rpc_evt_if.sink   evt,
    rpc_res_if.source res,
    rpc_cfg_if.sink   cfg
);
    import rpc_pkg::*;

    // configuration registers
    cfg_t      cfg_reg;

    // front to queue
    logic      push;
    cmd_t      push_cmd;

    // queue to back end
    cmd_t      head_cmd;
    q_status_t q_status;
    logic      pop;

    // config writes are always taken; indexes past the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_inner <= RST_TIMEOUT_INNER;
            cfg_reg.timeout_outer <= RST_TIMEOUT_OUTER;
            cfg_reg.max_depth     <= RST_MAX_DEPTH;
            cfg_reg.min_depth     <= RST_MIN_DEPTH;
            cfg_reg.limit_window  <= RST_LIMIT_WINDOW;
            cfg_reg.pwm_neutral   <= RST_PWM_NEUTRAL;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TIMEOUT_INNER: cfg_reg.timeout_inner <= cfg.data;
                REG_TIMEOUT_OUTER: cfg_reg.timeout_outer <= cfg.data;
                REG_MAX_DEPTH:     cfg_reg.max_depth     <= cfg.data[14:0];
                REG_MIN_DEPTH:     cfg_reg.min_depth     <= cfg.data;
                REG_LIMIT_WINDOW:  cfg_reg.limit_window  <= cfg.data[14:0];
                REG_PWM_NEUTRAL:   cfg_reg.pwm_neutral   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // front: accept and decode event kind
    rpc_front u_front (
        .evt      (evt),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    // two-entry queue so the back end can stall without blocking the front
    rpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // back end: state update and registered result
    rpc_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .res      (res)
    );

    // the back end only takes commands that are in the queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a popped command shows up as a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> res.valid)
        else $error("popped command produced no result");

    // a timed-out poll always reports the stop flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.poll_status == STAT_TIMEOUT) |-> res.stop_flag)
        else $error("timeout without stop flag");

endmodule

// ----- tb/reel_position_controller_tb.sv -----
// reel_position_controller_tb: self-checking bench for the reel position controller
// holds its own model of the controller state and checks every result in order
// depends on rpc_pkg, rpc_if and the reel_position_controller rtl

module reel_position_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpc_pkg::*;

    // kinds outside the defined set, the block must report state unchanged
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int SETTLE_CYCLES = 6;     // idle wait after the last result is checked
    localparam int LONG_HOLD     = 150;   // long receiver hold-off, fills the block
    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS   = 275;

    // one request as the sender sees it
    typedef struct packed {
        logic [2:0] kind;
        depth_t     target;
        logic       released;
        logic       rising;
        tick_t      timer;
    } reel_event_t;

    // directed table row: request plus an optional hand-typed result
    typedef struct packed {
        reel_event_t ev;
        logic        pinned;
        result_t     want;
    } script_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rpc_evt_if evt_ch ();
    rpc_res_if res_ch ();
    rpc_cfg_if cfg_ch ();

    reel_position_controller u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // shared knobs between the request and result sides
    logic gaps_on  = 1'b1;   // random gaps on both sides
    logic hold_off = 1'b0;   // ask the receiver for one long stall

    int requests_sent = 0;
    int mismatches    = 0;

    // results still owed by the block, oldest first
    result_t reports_due[$];

    // tracked controller state
    depth_t      trk_depth;
    logic [1:0]  trk_dir;
    logic        trk_running;
    logic        trk_stop;
    logic        trk_pullup;
    logic [1:0]  trk_event;
    depth_t      trk_hold;
    tick_t       trk_rise;
    tick_t       trk_width;
    logic [15:0] trk_polls_low;
    logic [15:0] trk_polls_high;
    logic [1:0]  trk_motor;

    // tracked configuration
    logic [15:0] set_inner;
    logic [15:0] set_outer;
    logic [14:0] set_max;
    depth_t      set_min;
    logic [14:0] set_window;
    logic [15:0] set_neutral;

    // ------------------------------------------------------------------
    // controller model: apply one request, return the state it reports
    // ------------------------------------------------------------------
    function automatic result_t advance_reel(input reel_event_t e);
        logic [2:0] status;
        result_t    r;
        status = STAT_IDLE;
        case (e.kind)
            KIND_POLL:
            begin
                // two-level timeout, inner count rolls into the outer one
                trk_polls_low = trk_polls_low + 16'd1;
                if (trk_polls_low > set_inner)
                begin
                    trk_polls_low  = '0;
                    trk_polls_high = trk_polls_high + 16'd1;
                end
                if (trk_polls_high > set_outer)
                begin
                    // timeout leaves drive and direction alone
                    trk_stop = 1'b1;
                    status   = STAT_TIMEOUT;
                end
                else if (trk_depth != e.target && e.released)
                begin
                    if (trk_depth > e.target)
                    begin
                        trk_dir   = MOVE_DOWN;
                        trk_motor = MOVE_DOWN;
                        status    = STAT_DOWN;
                    end
                    else
                    begin
                        trk_dir   = MOVE_UP;
                        trk_motor = MOVE_UP;
                        status    = STAT_UP;
                    end
                end
                else
                begin
                    // arrived, or switch pressed: halt everything
                    trk_dir     = MOVE_STOP;
                    trk_running = 1'b0;
                    trk_motor   = MOVE_STOP;
                    trk_stop    = 1'b1;
                    if (!e.released)
                    begin
                        trk_event = EVT_LIMERR;
                        status    = STAT_LIMIT;
                    end
                end
            end
            KIND_CLICK:
            begin
                if (trk_running && trk_dir == MOVE_UP)
                    trk_depth = trk_depth + 16'sd1;
                if (trk_running && trk_dir == MOVE_DOWN)
                    trk_depth = trk_depth - 16'sd1;
                // bounds follow the 16-bit wrap of the depth
                if (int'(trk_depth) > int'(set_max))
                begin
                    trk_stop    = 1'b1;
                    trk_running = 1'b0;
                    trk_event   = EVT_OOB;
                end
                if (int'(trk_depth) < int'(set_min))
                    trk_depth = '0;
                trk_polls_low  = '0;
                trk_polls_high = '0;
            end
            KIND_LIMIT:
            begin
                // switch level is ignored, every limit request is a press
                if (trk_dir == MOVE_UP && trk_running &&
                    int'(trk_depth) < int'(set_window))
                begin
                    trk_depth   = '0;
                    trk_dir     = MOVE_STOP;
                    trk_running = 1'b0;
                    trk_event   = trk_pullup ? EVT_NONE : EVT_HOME;
                end
                else
                begin
                    trk_running = 1'b0;
                    trk_event   = EVT_LIMERR;
                end
                trk_stop = 1'b1;
            end
            KIND_PWM:
            begin
                if (e.rising)
                    trk_rise = e.timer;
                else
                    trk_width = e.timer - trk_rise;
                // compare runs on both edges, so a rising edge sees the old width
                if (trk_width < set_neutral)
                begin
                    trk_hold       = PULLUP_TARGET;
                    trk_running    = 1'b1;
                    trk_dir        = MOVE_DOWN;
                    trk_stop       = 1'b0;
                    trk_pullup     = 1'b1;
                    trk_polls_low  = '0;
                    trk_polls_high = '0;
                end
                else if (trk_pullup)
                begin
                    trk_running = 1'b0;
                    trk_event   = EVT_NONE;
                    trk_hold    = trk_depth;
                    trk_stop    = 1'b1;
                    trk_pullup  = 1'b0;
                end
            end
            KIND_START:
            begin
                trk_running    = 1'b1;
                trk_stop       = 1'b0;
                trk_polls_low  = '0;
                trk_polls_high = '0;
                trk_event      = EVT_NONE;
            end
            default: ;
        endcase
        r.poll_status   = status;
        r.motor_drive   = trk_motor;
        r.depth         = trk_depth;
        r.direction     = trk_dir;
        r.stop_flag     = trk_stop;
        r.event_code    = trk_event;
        r.pullup_active = trk_pullup;
        r.held_target   = trk_hold;
        r.pulse_width   = trk_width;
        return r;
    endfunction

    function automatic result_t report(input logic [2:0] st, input logic [1:0] drv,
                                       input depth_t d, input logic [1:0] dir,
                                       input logic stp, input logic [1:0] ev,
                                       input logic pu, input depth_t held, input tick_t w);
        result_t r;
        r.poll_status   = st;
        r.motor_drive   = drv;
        r.depth         = d;
        r.direction     = dir;
        r.stop_flag     = stp;
        r.event_code    = ev;
        r.pullup_active = pu;
        r.held_target   = held;
        r.pulse_width   = w;
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf({"st=%0d drv=%0d depth=%0d dir=%0d stop=%0b ",
                          "evt=%0d pull=%0b held=%0d w=%0d"},
                         r.poll_status, r.motor_drive, r.depth, r.direction, r.stop_flag,
                         r.event_code, r.pullup_active, r.held_target, r.pulse_width);
    endfunction

    function automatic reel_event_t make_event(input logic [2:0] k, input depth_t t,
                                               input logic rel, input logic rise,
                                               input tick_t tm);
        reel_event_t e;
        e.kind     = k;
        e.target   = t;
        e.released = rel;
        e.rising   = rise;
        e.timer    = tm;
        return e;
    endfunction

    // every field random, unused fields included
    function automatic reel_event_t noise_event();
        reel_event_t e;
        e.kind     = 3'($urandom_range(0, 7));
        e.target   = depth_t'($urandom);
        e.released = 1'($urandom);
        e.rising   = 1'($urandom);
        e.timer    = tick_t'($urandom);
        return e;
    endfunction

    function automatic script_row_t free_row(input reel_event_t e);
        script_row_t s;
        s.ev     = e;
        s.pinned = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    function automatic script_row_t pinned_row(input reel_event_t e, input result_t w);
        script_row_t s;
        s.ev     = e;
        s.pinned = 1'b1;
        s.want   = w;
        return s;
    endfunction

    // compare one result with the oldest one owed
    function automatic void check_report(input result_t got);
        result_t want;
        if (reports_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %s", show(got));
            return;
        end
        want = reports_due.pop_front();
        if (got.poll_status   !== want.poll_status   ||
            got.motor_drive   !== want.motor_drive   ||
            got.depth         !== want.depth         ||
            got.direction     !== want.direction     ||
            got.stop_flag     !== want.stop_flag     ||
            got.event_code    !== want.event_code    ||
            got.pullup_active !== want.pullup_active ||
            got.held_target   !== want.held_target   ||
            got.pulse_width   !== want.pulse_width)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %s\n          actual   %s",
                         show(want), show(got));
        end
    endfunction

    // ------------------------------------------------------------------
    // request side: called at a falling edge, returns at a falling edge
    // with valid still high, so back-to-back requests never drop it
    // ------------------------------------------------------------------
    task automatic push_request(input reel_event_t e, input logic pinned, input result_t want);
        int      gap;
        result_t predicted;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            evt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_ch.valid        = 1'b1;
        evt_ch.kind         = e.kind;
        evt_ch.target_depth = e.target;
        evt_ch.limit_level  = e.released;
        evt_ch.pwm_level    = e.rising;
        evt_ch.timer_value  = e.timer;
        do @(posedge clk); while (!evt_ch.ready);
        predicted = advance_reel(e);
        reports_due.push_back(pinned ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic offer(input reel_event_t e);
        push_request(e, 1'b0, '0);
    endtask

    // stop offering and wait until the block has nothing left in flight
    task automatic drain_requests();
        evt_ch.valid = 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [15:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_TIMEOUT_INNER: set_inner   = val;
            REG_TIMEOUT_OUTER: set_outer   = val;
            REG_MAX_DEPTH:     set_max     = val[14:0];
            REG_MIN_DEPTH:     set_min     = val;
            REG_LIMIT_WINDOW:  set_window  = val[14:0];
            REG_PWM_NEUTRAL:   set_neutral = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] inner, input logic [15:0] outer,
                                  input logic [15:0] max_d, input logic [15:0] min_d,
                                  input logic [15:0] window, input logic [15:0] neutral);
        write_setting(REG_TIMEOUT_INNER, inner);
        write_setting(REG_TIMEOUT_OUTER, outer);
        write_setting(REG_MAX_DEPTH, max_d);
        write_setting(REG_MIN_DEPTH, min_d);
        write_setting(REG_LIMIT_WINDOW, window);
        write_setting(REG_PWM_NEUTRAL, neutral);
    endtask

    // one plausible operating sequence: start, polls, clicks, pwm pulses, maybe a limit
    task automatic play_session();
        reel_event_t e;
        tick_t       t0;
        tick_t       w;
        depth_t      aim;
        e = noise_event();
        e.kind = KIND_START;
        offer(e);
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    // target near the present depth, now and then anywhere
                    e = noise_event();
                    e.kind = KIND_POLL;
                    if ($urandom_range(0, 7) != 0)
                        e.target = trk_depth + depth_t'($urandom_range(0, 60)) - 16'sd30;
                    e.released = ($urandom_range(0, 15) != 0);
                    offer(e);
                end
                2, 3:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        e = noise_event();
                        e.kind = KIND_CLICK;
                        offer(e);
                    end
                end
                4:
                begin
                    // pulse width mostly close to neutral so both sides of it show up
                    t0 = tick_t'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        w = tick_t'($urandom);
                    else
                        w = set_neutral + tick_t'($urandom_range(0, 400)) - 16'd200;
                    e = noise_event();
                    e.kind   = KIND_PWM;
                    e.rising = 1'b1;
                    e.timer  = t0;
                    offer(e);
                    e = noise_event();
                    e.kind   = KIND_PWM;
                    e.rising = 1'b0;
                    e.timer  = t0 + w;
                    offer(e);
                end
                default:
                begin
                    // a run of polls at one target works the timeout counters
                    aim = trk_depth + depth_t'($urandom_range(0, 20)) - 16'sd10;
                    repeat ($urandom_range(1, 20))
                    begin
                        e = noise_event();
                        e.kind     = KIND_POLL;
                        e.target   = aim;
                        e.released = ($urandom_range(0, 31) != 0);
                        offer(e);
                    end
                end
            endcase
        end
        if ($urandom_range(0, 2) == 0)
        begin
            e = noise_event();
            e.kind = KIND_LIMIT;
            offer(e);
        end
    endtask

    // random part of one phase, with one long receiver stall and one full pause
    task automatic random_stretch(input int count);
        int   goal;
        logic held;
        logic paused;
        goal   = requests_sent + count;
        held   = 1'b0;
        paused = 1'b0;
        while (requests_sent < goal)
        begin
            if (!held && requests_sent > goal - count * 2 / 3)
            begin
                hold_off = 1'b1;
                held     = 1'b1;
            end
            if (!paused && requests_sent > goal - count / 3)
            begin
                drain_requests();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7)
                play_session();
            else
                offer(noise_event());
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int      gap;
        result_t got;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap != 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.poll_status   = res_ch.poll_status;
            got.motor_drive   = res_ch.motor_drive;
            got.depth         = res_ch.depth;
            got.direction     = res_ch.direction;
            got.stop_flag     = res_ch.stop_flag;
            got.event_code    = res_ch.event_code;
            got.pullup_active = res_ch.pullup_active;
            got.held_target   = res_ch.held_target;
            got.pulse_width   = res_ch.pulse_width;
            check_report(got);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake means the block is stuck
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        script_row_t script[$];
        result_t     at_rest;

        evt_ch.valid        = 1'b0;
        evt_ch.kind         = KIND_POLL;
        evt_ch.target_depth = '0;
        evt_ch.limit_level  = 1'b1;
        evt_ch.pwm_level    = 1'b0;
        evt_ch.timer_value  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_TIMEOUT_INNER;
        cfg_ch.data         = '0;

        // tracked state and configuration start from the reset values
        trk_depth      = '0;
        trk_dir        = MOVE_STOP;
        trk_running    = 1'b0;
        trk_stop       = 1'b1;
        trk_pullup     = 1'b0;
        trk_event      = EVT_NONE;
        trk_hold       = '0;
        trk_rise       = '0;
        trk_width      = '0;
        trk_polls_low  = '0;
        trk_polls_high = '0;
        trk_motor      = MOVE_STOP;
        set_inner      = RST_TIMEOUT_INNER;
        set_outer      = RST_TIMEOUT_OUTER;
        set_max        = RST_MAX_DEPTH;
        set_min        = RST_MIN_DEPTH;
        set_window     = RST_LIMIT_WINDOW;
        set_neutral    = RST_PWM_NEUTRAL;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, default configuration
        at_rest = report(STAT_IDLE, MOVE_STOP, 16'sd0, MOVE_STOP, 1'b1, EVT_NONE,
                         1'b0, 16'sd0, 16'h0000);
        // unknown kind straight after reset shows the reset state
        script.push_back(pinned_row(make_event(KIND_SPARE7, 16'sd0, 1'b1, 1'b1, 16'hFFFF),
                                    at_rest));
        // poll at the present depth: arrived, nothing moves
        script.push_back(pinned_row(make_event(KIND_POLL, 16'sd0, 1'b1, 1'b0, 16'h0000),
                                    at_rest));
        // poll with switch pressed: limit error
        script.push_back(pinned_row(make_event(KIND_POLL, 16'sd0, 1'b0, 1'b0, 16'h0000),
                                    report(STAT_LIMIT, MOVE_STOP, 16'sd0, MOVE_STOP, 1'b1,
                                           EVT_LIMERR, 1'b0, 16'sd0, 16'h0000)));
        // start clears the stop flag and the sticky event
        script.push_back(pinned_row(make_event(KIND_START, 16'sd0, 1'b0, 1'b0, 16'h0000),
                                    report(STAT_IDLE, MOVE_STOP, 16'sd0, MOVE_STOP, 1'b0,
                                           EVT_NONE, 1'b0, 16'sd0, 16'h0000)));
        // highest target: drive up
        script.push_back(pinned_row(make_event(KIND_POLL, 16'sd32767, 1'b1, 1'b0, 16'h0000),
                                    report(STAT_UP, MOVE_UP, 16'sd0, MOVE_UP, 1'b0,
                                           EVT_NONE, 1'b0, 16'sd0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_CLICK, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_CLICK, -16'sd1, 1'b0, 1'b1, 16'hFFFF)));
        // limit while going up near zero: home hit, level not looked at
        script.push_back(free_row(make_event(KIND_LIMIT, 16'sd0, 1'b0, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_START, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        // lowest target: drive down, the next click clamps at the lower bound
        script.push_back(free_row(make_event(KIND_POLL, -16'sd32768, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_CLICK, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        // rising edge sees the stale zero width and starts a pull-up
        script.push_back(free_row(make_event(KIND_PWM, 16'sd0, 1'b1, 1'b1, 16'hFFFF)));
        // falling edge across the timer wrap, wide pulse ends the pull-up
        script.push_back(free_row(make_event(KIND_PWM, 16'sd0, 1'b1, 1'b0, 16'd3999)));
        script.push_back(free_row(make_event(KIND_PWM, 16'sd0, 1'b1, 1'b1, 16'h0000)));
        // narrow pulse forces a pull-up again
        script.push_back(free_row(make_event(KIND_PWM, 16'sd0, 1'b1, 1'b0, 16'd100)));
        // limit while pulling down: error
        script.push_back(free_row(make_event(KIND_LIMIT, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_START, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_POLL, 16'sd5, 1'b1, 1'b0, 16'h0000)));
        // home hit during a pull-up leaves the event at none
        script.push_back(free_row(make_event(KIND_LIMIT, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_POLL, 16'sd3, 1'b0, 1'b1, 16'hFFFF)));
        script.push_back(free_row(make_event(KIND_SPARE5, -16'sd1, 1'b0, 1'b1, 16'hFFFF)));
        script.push_back(free_row(make_event(KIND_SPARE6, 16'sd1, 1'b1, 1'b0, 16'h5555)));
        // click with nothing running only clears the timeout counters
        script.push_back(free_row(make_event(KIND_CLICK, 16'sd0, 1'b1, 1'b0, 16'h0000)));
        script.push_back(free_row(make_event(KIND_POLL, -16'sd1, 1'b1, 1'b0, 16'hAAAA)));

        foreach (script[i])
            push_request(script[i].ev, script[i].pinned, script[i].want);

        // random phases, each under its own configuration
        for (int p = 0; p < 6; p++)
        begin
            drain_requests();
            case (p)
                0: ;   // reset configuration
                1: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'd3, 16'd2, 16'd60, 16'hFFEC, 16'd30, 16'd3000);
                default: apply_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
                                        16'($urandom), 16'($urandom_range(0, 40)) - 16'd20,
                                        16'($urandom), 16'($urandom_range(2000, 4000)));
            endcase
            random_stretch(PHASE_ITEMS);
        end

        drain_requests();
        if (mismatches == 0 && reports_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
